/* hdl/skt_pkg.sv */
// Shared types, key codes, character tables and byte helpers for the
// Sinhala key transliterator. No dependencies; every other file imports this package.
package skt_pkg;

   localparam int SKT_QUEUE_DEPTH = 2;
   localparam int NUM_CONS        = 40;
   localparam int NUM_VOW         = 11;
   localparam int SEQ_LEN         = 9;

   localparam logic [15:0] KEY_SHIFT_L = 16'hffe1;
   localparam logic [15:0] KEY_SHIFT_R = 16'hffe2;
   localparam logic [15:0] KEY_CTRL_L  = 16'hffe3;
   localparam logic [15:0] KEY_CTRL_R  = 16'hffe4;
   localparam logic [15:0] KEY_SPACE   = 16'h0020;

   localparam logic [7:0] LEAD_SINHALA = 8'he0;
   localparam logic [7:0] LEAD_PUNCT   = 8'he2;
   localparam logic [7:0] PAGE_LOW     = 8'hb6;
   localparam logic [7:0] PAGE_HIGH    = 8'hb7;
   localparam logic [7:0] CONT_BASE    = 8'h80;
   localparam logic [7:0] HIGH_START   = 8'hc0;
   localparam logic [7:0] HIGH_SET     = 8'h40;
   localparam logic [7:0] LOW_MASK     = 8'h3f;
   localparam logic [7:0] ZWNJ_LSB     = 8'h0c;
   localparam logic [7:0] ZWJ_LSB      = 8'h0d;
   localparam logic [7:0] ZWNJ_TAIL    = 8'h8c;
   localparam logic [7:0] ZWJ_TAIL     = 8'h8d;
   localparam logic [7:0] AL_LAKUNA    = 8'hca;
   localparam logic [7:0] CONS_LO      = 8'h9a;
   localparam logic [7:0] CONS_HI      = 8'hc6;
   localparam logic [7:0] YANS_LAST    = 8'hba;

   typedef struct packed {
      logic [15:0] key_code;
      logic        is_release;
      logic        other_modifier;
      logic        prev_valid;
      logic [7:0]  prev_byte_first;
      logic [7:0]  prev_byte_second;
      logic [7:0]  prev_byte_third;
   } req_type;

   typedef struct packed {
      logic       handled;
      logic       delete_prev;
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // What the back end has to emit for one request
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ASCII,
      OP_CHAR,
      OP_BANDI,
      OP_RAKAR,
      OP_YANS
   } op_type;

   typedef struct packed {
      logic       handled;
      logic       delete_prev;
      op_type     op;
      logic [7:0] value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [7:0] base;
      logic [7:0] aspir;
      logic [7:0] nasal;
      logic [7:0] key;
   } cons_entry_type;

   typedef struct packed {
      logic [7:0] s0;
      logic [7:0] d0;
      logic [7:0] s1;
      logic [7:0] d1;
      logic [7:0] key;
   } vow_entry_type;

   localparam cons_entry_type CONS_TAB [NUM_CONS] = '{
      '{8'ha4, 8'h00, 8'h00, "q"}, '{8'ha5, 8'h00, 8'h00, "Q"},
      '{8'hc0, 8'h00, 8'h00, "w"}, '{8'h0c, 8'h00, 8'h00, "W"},
      '{8'hbb, 8'h00, 8'h00, "r"}, '{8'hbb, 8'h00, 8'h00, "R"},
      '{8'had, 8'hae, 8'h00, "t"}, '{8'ha7, 8'ha8, 8'h00, "T"},
      '{8'hba, 8'h00, 8'h00, "y"}, '{8'hba, 8'h00, 8'h00, "Y"},
      '{8'hb4, 8'hb5, 8'h00, "p"}, '{8'hb5, 8'hb5, 8'h00, "P"},
      '{8'hc3, 8'hc2, 8'h00, "s"}, '{8'hc1, 8'hc2, 8'h00, "S"},
      '{8'haf, 8'hb0, 8'hb3, "d"}, '{8'ha9, 8'haa, 8'hac, "D"},
      '{8'hc6, 8'h00, 8'h00, "f"}, '{8'hc6, 8'h00, 8'h00, "F"},
      '{8'h9c, 8'h9d, 8'h9f, "g"}, '{8'h9f, 8'h9d, 8'h00, "G"},
      '{8'hc4, 8'h83, 8'h00, "h"}, '{8'hc4, 8'h00, 8'h00, "H"},
      '{8'ha2, 8'ha3, 8'ha6, "j"}, '{8'ha3, 8'ha3, 8'ha6, "J"},
      '{8'h9a, 8'h9b, 8'h00, "k"}, '{8'h9b, 8'h9b, 8'h00, "K"},
      '{8'hbd, 8'h00, 8'h00, "l"}, '{8'hc5, 8'h00, 8'h00, "L"},
      '{8'h82, 8'h00, 8'h00, "x"}, '{8'h9e, 8'h00, 8'h00, "X"},
      '{8'ha0, 8'ha1, 8'h00, "c"}, '{8'ha1, 8'ha1, 8'h00, "C"},
      '{8'hc0, 8'h00, 8'h00, "v"}, '{8'hc0, 8'h00, 8'h00, "V"},
      '{8'hb6, 8'hb7, 8'hb9, "b"}, '{8'hb7, 8'hb7, 8'hb9, "B"},
      '{8'hb1, 8'h00, 8'h82, "n"}, '{8'hab, 8'h00, 8'h9e, "N"},
      '{8'hb8, 8'h00, 8'h00, "m"}, '{8'hb9, 8'h00, 8'h00, "M"}
   };

   localparam vow_entry_type VOW_TAB [NUM_VOW] = '{
      '{8'h85, 8'h86, 8'hcf, 8'hcf, "a"}, '{8'h87, 8'h88, 8'hd0, 8'hd1, "A"},
      '{8'h91, 8'h92, 8'hd9, 8'hda, "e"}, '{8'h91, 8'h92, 8'hd9, 8'hda, "E"},
      '{8'h89, 8'h8a, 8'hd2, 8'hd3, "i"}, '{8'h93, 8'h00, 8'hdb, 8'hdb, "I"},
      '{8'h94, 8'h95, 8'hdc, 8'hdd, "o"}, '{8'h96, 8'h00, 8'hde, 8'hdf, "O"},
      '{8'h8b, 8'h8c, 8'hd4, 8'hd6, "u"}, '{8'h8d, 8'h8e, 8'hd8, 8'hf2, "U"},
      '{8'h8f, 8'h90, 8'h8f, 8'h90, "Z"}
   };

   // al-lakuna + ZWJ, then ra for rakaransaya (ya swaps in the last byte)
   localparam logic [7:0] SEQ_TAB [SEQ_LEN] = '{
      8'he0, 8'hb7, 8'h8a, 8'he2, 8'h80, 8'h8d, 8'he0, 8'hb6, 8'hbb
   };

   function automatic logic [7:0] decode_prev(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2);
      logic [7:0] r;
      r = 8'h00;
      if (b0 == LEAD_SINHALA) begin
         if (b1 == PAGE_LOW) r = b2;
         else if (b1 == PAGE_HIGH) r = b2 | HIGH_SET;
      end else if (b0 == LEAD_PUNCT && b1 == CONT_BASE) begin
         if (b2 == ZWNJ_TAIL) r = ZWNJ_LSB;
         else if (b2 == ZWJ_TAIL) r = ZWJ_LSB;
      end
      return r;
   endfunction

   // A character low byte that encodes to three UTF-8 bytes
   function automatic logic char_encodable(input logic [7:0] lsb);
      return lsb[7] || lsb == ZWNJ_LSB || lsb == ZWJ_LSB;
   endfunction

   function automatic logic [7:0] char_byte(input logic [7:0] lsb, input logic [1:0] idx);
      logic [7:0] r;
      logic       low_page;
      low_page = lsb < HIGH_START;
      case (idx)
         2'd0:    r = lsb[7] ? LEAD_SINHALA : LEAD_PUNCT;
         2'd1:    r = lsb[7] ? (low_page ? PAGE_LOW : PAGE_HIGH) : CONT_BASE;
         default: r = lsb[7] ? (low_page ? lsb : ((lsb & LOW_MASK) | CONT_BASE))
                             : (CONT_BASE | lsb);
      endcase
      return r;
   endfunction

   function automatic logic [3:0] op_count(input op_type op);
      logic [3:0] n;
      unique case (op) inside
         OP_NONE:           n = 4'd0;
         OP_ASCII:          n = 4'd1;
         OP_CHAR:           n = 4'd3;
         OP_BANDI:          n = 4'd6;
         OP_RAKAR, OP_YANS: n = 4'd9;
         default:           n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] cmd_byte(input cmd_type cmd, input logic [3:0] idx);
      logic [7:0] seq;
      logic [7:0] r;
      seq = (idx < 4'(SEQ_LEN)) ? SEQ_TAB[idx] : 8'h00;
      unique case (cmd.op) inside
         OP_ASCII:           r = cmd.value;
         OP_CHAR:            r = char_byte(cmd.value, idx[1:0]);
         OP_BANDI, OP_RAKAR: r = seq;
         OP_YANS:            r = (idx == 4'(SEQ_LEN - 1)) ? YANS_LAST : seq;
         default:            r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

/* hdl/skt_front.sv */
// Front end: accepts key requests, tracks modifier and mode state, and
// turns each request into one emit command. Depends on skt_pkg.
module skt_front
   import skt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             push,
   output cmd_type          push_cmd
);

   logic shift_l_ff, shift_r_ff, ctrl_l_ff, ctrl_r_ff, sinhala_ff;
   logic shift_l_in, shift_r_in, ctrl_l_in, ctrl_r_in, sinhala_in;

   logic           accept;
   logic [7:0]     prev;
   logic           ci_hit, l1_hit, vi_hit, ascii_key;
   cons_entry_type ci_ent, l1_ent;
   vow_entry_type  vi_ent;
   logic [7:0]     c1;
   logic [7:0]     char_val;
   logic           char_del, char_sel;
   cmd_type        cmd;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept;
   assign push_cmd  = cmd;

   // Table searches; the previous-character search keeps the lowest match
   always_comb begin
      prev   = decode_prev(req_data.prev_byte_first, req_data.prev_byte_second,
                           req_data.prev_byte_third);
      ci_hit = 1'b0;
      ci_ent = CONS_TAB[0];
      l1_hit = 1'b0;
      l1_ent = CONS_TAB[0];
      vi_hit = 1'b0;
      vi_ent = VOW_TAB[0];
      for (int i = NUM_CONS - 1; i >= 0; i--) begin
         if (req_data.key_code == {8'h00, CONS_TAB[i].key}) begin
            ci_hit = 1'b1;
            ci_ent = CONS_TAB[i];
         end
         if (prev != 8'h00 && (CONS_TAB[i].base == prev || CONS_TAB[i].aspir == prev ||
                               CONS_TAB[i].nasal == prev)) begin
            l1_hit = 1'b1;
            l1_ent = CONS_TAB[i];
         end
      end
      for (int i = NUM_VOW - 1; i >= 0; i--) begin
         if (req_data.key_code == {8'h00, VOW_TAB[i].key}) begin
            vi_hit = 1'b1;
            vi_ent = VOW_TAB[i];
         end
      end
      l1_hit = l1_hit && req_data.prev_valid;
      c1     = req_data.prev_valid ? prev : 8'h00;
   end

   always_comb begin
      shift_l_in = shift_l_ff;
      shift_r_in = shift_r_ff;
      ctrl_l_in  = ctrl_l_ff;
      ctrl_r_in  = ctrl_r_ff;
      sinhala_in = sinhala_ff;
      ascii_key  = req_data.key_code[15:7] == 9'd0;
      char_sel   = 1'b0;
      char_del   = 1'b0;
      char_val   = 8'h00;
      cmd        = '{handled: 1'b0, delete_prev: 1'b0, op: OP_NONE, value: 8'h00};

      if (req_data.key_code == 16'h0000) begin
         cmd.handled = 1'b0;
      end else if (req_data.is_release) begin
         if (req_data.key_code == KEY_SHIFT_L) shift_l_in = 1'b0;
         if (req_data.key_code == KEY_SHIFT_R) shift_r_in = 1'b0;
         if (req_data.key_code == KEY_CTRL_L)  ctrl_l_in  = 1'b0;
         if (req_data.key_code == KEY_CTRL_R)  ctrl_r_in  = 1'b0;
      end else if (req_data.key_code == KEY_SHIFT_L) begin
         shift_l_in = 1'b1;
      end else if (req_data.key_code == KEY_SHIFT_R) begin
         shift_r_in = 1'b1;
      end else if (req_data.key_code == KEY_CTRL_L) begin
         ctrl_l_in = 1'b1;
      end else if (req_data.key_code == KEY_CTRL_R) begin
         ctrl_r_in = 1'b1;
      end else if (req_data.key_code == KEY_SPACE && (shift_l_ff || shift_r_ff)) begin
         cmd.handled = 1'b1;
      end else if (req_data.key_code == KEY_SPACE && (ctrl_l_ff || ctrl_r_ff)) begin
         sinhala_in  = !sinhala_ff;
         cmd.handled = 1'b1;
      end else if (req_data.other_modifier) begin
         cmd.handled = 1'b0;
      end else if (!sinhala_ff && ascii_key) begin
         cmd.handled = 1'b1;
         cmd.op      = OP_ASCII;
         cmd.value   = req_data.key_code[7:0];
      end else if (ci_hit) begin
         cmd.handled = 1'b1;
         if (l1_hit && req_data.key_code[7:0] == "w") begin
            char_sel = 1'b1;
            char_val = AL_LAKUNA;
         end else if (l1_hit && req_data.key_code[7:0] == "W") begin
            cmd.op = OP_BANDI;
         end else if (l1_hit && req_data.key_code[7:0] == "H" && l1_ent.aspir != 8'h00) begin
            char_sel = 1'b1;
            char_del = 1'b1;
            char_val = l1_ent.aspir;
         end else if (l1_hit && req_data.key_code[7:0] == "G" && l1_ent.nasal != 8'h00) begin
            char_sel = 1'b1;
            char_del = 1'b1;
            char_val = l1_ent.nasal;
         end else if (l1_hit && req_data.key_code[7:0] == "R") begin
            cmd.op = OP_RAKAR;
         end else if (l1_hit && req_data.key_code[7:0] == "Y") begin
            cmd.op = OP_YANS;
         end else begin
            char_sel = 1'b1;
            char_val = ci_ent.base;
         end
      end else if (vi_hit) begin
         cmd.handled = 1'b1;
         char_sel    = 1'b1;
         if (c1 >= CONS_LO && c1 <= CONS_HI) begin
            char_val = vi_ent.s1;
         end else if (c1 != 8'h00 && c1 == vi_ent.s0 && vi_ent.d0 != 8'h00) begin
            char_del = 1'b1;
            char_val = vi_ent.d0;
         end else if (c1 != 8'h00 && c1 == vi_ent.s1) begin
            char_del = 1'b1;
            char_val = vi_ent.d1;
         end else begin
            char_val = vi_ent.s0;
         end
      end else if (ascii_key) begin
         cmd.handled = 1'b1;
         cmd.op      = OP_ASCII;
         cmd.value   = req_data.key_code[7:0];
      end

      if (char_sel) begin
         cmd.delete_prev = char_del;
         cmd.value       = char_val;
         cmd.op          = char_encodable(char_val) ? OP_CHAR : OP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_l_ff <= 1'b0;
         shift_r_ff <= 1'b0;
         ctrl_l_ff  <= 1'b0;
         ctrl_r_ff  <= 1'b0;
         sinhala_ff <= 1'b1;
      end else if (accept) begin
         shift_l_ff <= shift_l_in;
         shift_r_ff <= shift_r_in;
         ctrl_l_ff  <= ctrl_l_in;
         ctrl_r_ff  <= ctrl_r_in;
         sinhala_ff <= sinhala_in;
      end
   end

endmodule

/* hdl/skt_queue.sv */
// Small command FIFO between the front and back ends.
// Depends on skt_pkg.
module skt_queue
   import skt_pkg::*;
#(
   parameter int DEPTH = SKT_QUEUE_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.full  = count_ff == CNT_W'(DEPTH);
   assign status.empty = count_ff == '0;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

/* hdl/skt_back.sv */
// Back end: expands each queued command into its UTF-8 bytes, one result
// per cycle while rsp_stall is low, through a registered result stage. Depends on skt_pkg.
module skt_back
   import skt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          head_cmd,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic [3:0] idx_ff, idx_in;
   logic [3:0] count;
   logic       load, last_byte;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      load         = !rsp_valid_ff || !rsp_stall;
      count        = op_count(head_cmd.op);
      last_byte    = (count == 4'd0) || (idx_ff == count - 4'd1);
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      idx_in       = idx_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = !q_status.empty;
         if (!q_status.empty) begin
            rsp_data_in.handled     = head_cmd.handled;
            rsp_data_in.delete_prev = head_cmd.delete_prev;
            rsp_data_in.byte_valid  = count != 4'd0;
            rsp_data_in.out_byte    = cmd_byte(head_cmd, idx_ff);
            rsp_data_in.last        = last_byte;
            pop                     = last_byte;
            idx_in                  = last_byte ? 4'd0 : idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* hdl/sinhala_key_transliterator_unit.sv */
// Top level of the Sinhala key transliterator: front end, command queue, back end.
// Depends on skt_pkg, skt_front, skt_queue and skt_back.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   req_data (req_type): one key event
//   rsp_      out        rsp_valid / rsp_stall   rsp_data (rsp_type): one result byte
//
// A request is taken whenever the command queue has room.
// The back end sends max(1, bytes) results per request (1, 3, 6 or 9),
// one per cycle while rsp_stall is low, so the byte expansion in the back end sets the rate.
// A taken request is first written into the command queue; its first result is then registered in the result stage.
// Synchronous reset clears the queue and result stage; Sinhala mode comes up on.
// rsp_stall holds the result register; the queue keeps taking requests until full.
module sinhala_key_transliterator_unit
   import skt_pkg::*;
#(
   parameter int QUEUE_DEPTH = SKT_QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   queue_status_type q_status;
   logic             push, pop;
   cmd_type          push_cmd, head_cmd;

   skt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   skt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   skt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
